### rtl/ili_pkg.sv
package ili_pkg;

    // Field widths of the request and response beats
    localparam int OPCODE_W = 3;
    localparam int POS_W    = 6;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // Width of positions and counts inside the cell row (covers DEPTH up to 1024)
    localparam int IDX_W = 11;

    // Fan-in of one node of the read gather tree
    localparam int RADIX = 8;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_POP    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_READ   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [POS_W-1:0]    position;
        word_t               value;
    } req_t;

    typedef struct packed {
        word_t               read_value;
        logic [COUNT_W-1:0]  item_count;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // What each cell does with its entry on an accepted beat
    typedef enum logic [1:0] {
        SH_NONE,
        SH_INS,
        SH_DEL
    } shift_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        shift_t           kind;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] last;
        word_t            value;
        logic             load;
        logic             hit_en;
        logic [IDX_W-1:0] tap_sel;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_OUT
    } state_t;

    // Node count of a tree level, level zero being the leaves
    function automatic int nodes_at(input int n, input int k);
        int m;
        m = n;
        for (int l = 0; l < k; l++) begin
            m = (m + RADIX - 1) / RADIX;
        end
        return m;
    endfunction

    // Number of registered levels needed to reduce n leaves to one
    function automatic int tree_levels(input int n);
        int m;
        int l;
        m = n;
        l = 0;
        while (m > 1) begin
            m = (m + RADIX - 1) / RADIX;
            l++;
        end
        return l;
    endfunction

endpackage

### rtl/ili_cell.sv
module ili_cell #(
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  ili_pkg::cell_ctrl_t ctrl,
    input  ili_pkg::word_t      left,
    input  ili_pkg::word_t      right,
    output ili_pkg::word_t      entry,
    output ili_pkg::word_t      tap
);

    localparam int IW = ili_pkg::IDX_W;
    localparam logic [IW-1:0] IDX      = IW'(INDEX);
    localparam logic [IW-1:0] IDX_NEXT = IW'(INDEX + 1);

    ili_pkg::word_t entry_reg;
    ili_pkg::word_t entry_next;
    ili_pkg::word_t tap_reg;
    ili_pkg::word_t tap_next;

    // Decide this cell's own move from the broadcast position
    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.kind)
            ili_pkg::SH_INS:
            begin
                if (IDX == ctrl.pos)
                begin
                    entry_next = ctrl.value;
                end
                else if (IDX > ctrl.pos && IDX <= ctrl.last)
                begin
                    entry_next = left;
                end
            end
            ili_pkg::SH_DEL:
            begin
                if (IDX >= ctrl.pos && IDX_NEXT < ctrl.last)
                begin
                    entry_next = right;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // On an accepted beat offer the current word to the gather tree when selected, else zero; else hold
    always_comb
    begin
        tap_next = tap_reg;
        if (ctrl.load)
        begin
            tap_next = (ctrl.hit_en && IDX == ctrl.tap_sel) ? entry_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        tap_reg   <= tap_next;
    end

    assign entry = entry_reg;
    assign tap   = tap_reg;

endmodule

### rtl/ili_or_tree.sv
module ili_or_tree #(
    parameter int N = 64
) (
    input  logic           clk,
    input  ili_pkg::word_t leaf [N],
    output ili_pkg::word_t root
);

    localparam int RX   = ili_pkg::RADIX;
    localparam int LVLS = ili_pkg::tree_levels(N);
    localparam int N1   = ili_pkg::nodes_at(N, 1);

    ili_pkg::word_t lvl [1:LVLS][N1];

    // Reduce each group of RADIX nodes into one register per level
    for (genvar k = 1; k <= LVLS; k++)
    begin : g_lvl
        localparam int NPREV = ili_pkg::nodes_at(N, k - 1);
        localparam int NCUR  = ili_pkg::nodes_at(N, k);
        for (genvar j = 0; j < N1; j++)
        begin : g_node
            if (j < NCUR)
            begin : g_used
                ili_pkg::word_t kid [RX];
                ili_pkg::word_t or_val;
                for (genvar c = 0; c < RX; c++)
                begin : g_kid
                    if (j * RX + c >= NPREV)
                    begin : g_pad
                        assign kid[c] = '0;
                    end
                    else if (k == 1)
                    begin : g_leaf
                        assign kid[c] = leaf[j * RX + c];
                    end
                    else
                    begin : g_inner
                        assign kid[c] = lvl[k - 1][j * RX + c];
                    end
                end
                always_comb
                begin
                    or_val = '0;
                    for (int c = 0; c < RX; c++)
                    begin
                        or_val = or_val | kid[c];
                    end
                end
                always_ff @(posedge clk)
                begin
                    lvl[k][j] <= or_val;
                end
            end
            else
            begin : g_unused
                assign lvl[k][j] = '0;
            end
        end
    end

    assign root = lvl[LVLS][0];

endmodule

### rtl/indexed_list_insert_delete.sv
// Ordered list held in a row of cells, one word per cell; each cell shifts itself on an accepted beat.
// The read word passes through the cell tap registers and then the LVLS levels of the
// radix-8 registered OR tree (2 at DEPTH = 64, 4 at 1024); rsp_valid rises as it reaches the root.
// Only one request is in flight: req_ready stays low until the response is taken with rsp_ready.
// Reset: rst_n clears the element count and the controller; stored words are not cleared.
module indexed_list_insert_delete #(
    parameter int DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ili_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ili_pkg::rsp_t rsp
);

    localparam int IW     = ili_pkg::IDX_W;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LVLS   = ili_pkg::tree_levels(DEPTH);
    localparam int WAIT_W = (LVLS > 1) ? $clog2(LVLS) : 1;
    localparam logic [IW-1:0] DEPTH_W = IW'(DEPTH);

    ili_pkg::state_t state_reg;
    ili_pkg::state_t state_next;
    logic [WAIT_W-1:0] wait_reg;
    logic [WAIT_W-1:0] wait_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [ili_pkg::COUNT_W-1:0] count_reg;
    logic [ili_pkg::STATUS_W-1:0] status_reg;
    logic [ili_pkg::STATUS_W-1:0] status_next;

    logic accept;
    logic [IW-1:0] fill_w;
    logic [IW-1:0] pos_w;
    logic [IW-1:0] fill_after;
    logic full;
    logic empty;
    ili_pkg::shift_t kind_dec;
    logic [IW-1:0] pos_dec;
    logic hit_dec;
    logic [IW-1:0] sel_dec;
    ili_pkg::cell_ctrl_t ctrl;

    ili_pkg::word_t entry [DEPTH];
    ili_pkg::word_t tap [DEPTH];
    ili_pkg::word_t root;

    assign accept = req_valid && req_ready;
    assign fill_w = IW'(fill_reg);
    assign pos_w  = IW'(req.position);
    assign full   = (fill_w == DEPTH_W);
    assign empty  = (fill_w == '0);

    // Decode the request into a cell command, new count and status
    always_comb
    begin
        kind_dec    = ili_pkg::SH_NONE;
        pos_dec     = pos_w;
        hit_dec     = 1'b0;
        sel_dec     = pos_w;
        fill_next   = fill_reg;
        status_next = ili_pkg::ST_OK;
        case (req.opcode)
            ili_pkg::OP_PUSH:
            begin
                if (full)
                begin
                    status_next = ili_pkg::ST_FULL;
                end
                else
                begin
                    kind_dec  = ili_pkg::SH_INS;
                    pos_dec   = fill_w;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            ili_pkg::OP_POP:
            begin
                if (empty)
                begin
                    status_next = ili_pkg::ST_EMPTY;
                end
                else
                begin
                    hit_dec   = 1'b1;
                    sel_dec   = fill_w - IW'(1);
                    fill_next = fill_reg - CNT_W'(1);
                end
            end
            ili_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    status_next = ili_pkg::ST_FULL;
                end
                else if (pos_w > fill_w)
                begin
                    status_next = ili_pkg::ST_RANGE;
                end
                else
                begin
                    kind_dec  = ili_pkg::SH_INS;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            ili_pkg::OP_DELETE:
            begin
                if (empty)
                begin
                    status_next = ili_pkg::ST_EMPTY;
                end
                else if (pos_w >= fill_w)
                begin
                    status_next = ili_pkg::ST_RANGE;
                end
                else
                begin
                    kind_dec  = ili_pkg::SH_DEL;
                    fill_next = fill_reg - CNT_W'(1);
                end
            end
            ili_pkg::OP_READ:
            begin
                if (empty)
                begin
                    status_next = ili_pkg::ST_EMPTY;
                end
                else if (pos_w >= fill_w)
                begin
                    status_next = ili_pkg::ST_RANGE;
                end
                else
                begin
                    hit_dec = 1'b1;
                end
            end
            default:
            begin
                status_next = ili_pkg::ST_OK;
            end
        endcase
    end

    assign fill_after = IW'(fill_next);

    // Broadcast the command to the row only on an accepted beat
    always_comb
    begin
        ctrl.kind    = accept ? kind_dec : ili_pkg::SH_NONE;
        ctrl.pos     = pos_dec;
        ctrl.last    = fill_w;
        ctrl.value   = req.value;
        ctrl.load    = accept;
        ctrl.hit_en  = hit_dec;
        ctrl.tap_sel = sel_dec;
    end

    // Row of storage cells, each wired to its two neighbors
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        ili_pkg::word_t left_w;
        ili_pkg::word_t right_w;
        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = entry[i - 1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = entry[i + 1];
        end
        ili_cell #(
            .INDEX(i)
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .left  (left_w),
            .right (right_w),
            .entry (entry[i]),
            .tap   (tap[i])
        );
    end

    // Gather the selected word
    ili_or_tree #(
        .N(DEPTH)
    ) u_tree (
        .clk  (clk),
        .leaf (tap),
        .root (root)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        case (state_reg)
            ili_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ili_pkg::S_WAIT;
                    wait_next  = WAIT_W'(LVLS - 1);
                end
            end
            ili_pkg::S_WAIT:
            begin
                if (wait_reg == '0)
                begin
                    state_next = ili_pkg::S_OUT;
                end
                else
                begin
                    wait_next = wait_reg - WAIT_W'(1);
                end
            end
            ili_pkg::S_OUT:
            begin
                if (rsp_ready)
                begin
                    state_next = ili_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ili_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the controller
    always_comb
    begin
        req_ready = (state_reg == ili_pkg::S_IDLE);
        rsp_valid = (state_reg == ili_pkg::S_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ili_pkg::S_IDLE;
            wait_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            if (accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    // Hold count and status of the beat in flight
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            count_reg  <= fill_after[ili_pkg::COUNT_W-1:0];
            status_reg <= status_next;
        end
    end

    assign rsp.read_value = root;
    assign rsp.item_count = count_reg;
    assign rsp.status     = status_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("element count above capacity");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ili_pkg::ST_OK |-> rsp.read_value == '0)
        else $error("failed request returned a nonzero word");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready && !rsp_valid)
        else $error("request taken while another is in flight");

endmodule
